[hdl/psfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psfr_pkg;

    // Coordinate and force words, signed Q16.16.
    typedef logic signed [31:0] t_coord;

    // Configuration data, unsigned Q8.16.
    typedef logic [23:0] t_cfg;

    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K0   = 3'd0,
        CFG_K1   = 3'd1,
        CFG_L0   = 3'd2,
        CFG_L1   = 3'd3,
        CFG_CUT  = 3'd4
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam t_cfg RST_K0  = 24'd65536;
    localparam t_cfg RST_K1  = 24'd131072;
    localparam t_cfg RST_L0  = 24'd13107;
    localparam t_cfg RST_L1  = 24'd9830;
    localparam t_cfg RST_CUT = 24'd32768;

    // Pipeline layout: square root and divider run four steps per stage.
    localparam int SQ_STEP = 4;
    localparam int SQ_STG  = 8;
    localparam int DV_STEP = 4;
    localparam int DV_STG  = 14;
    localparam int Q_W     = DV_STEP * DV_STG;

    localparam int ST_DIFF = 0;
    localparam int ST_SQR  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_RT0  = 3;
    localparam int ST_DEV  = ST_RT0 + SQ_STG;
    localparam int ST_KPR  = ST_DEV + 1;
    localparam int ST_DV0  = ST_KPR + 1;
    localparam int ST_PP   = ST_DV0 + DV_STG;
    localparam int ST_MAG  = ST_PP + 1;
    localparam int ST_OUT  = ST_MAG + 1;
    localparam int N_STG   = ST_OUT + 1;

    // Per-pair facts that travel alongside the arithmetic.
    typedef struct packed {
        logic [2:0][23:0] dm;
        logic [2:0]       dneg;
        logic             sat_d;
        logic             in_cut;
        logic [24:0]      ksum;
        logic [31:0]      rest24;
        logic             cneg;
    } t_side;

    // Square root stage contents.
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] x;
        t_side       side;
    } t_sq;

    // Divider stage contents.
    typedef struct packed {
        logic [31:0]    rem;
        logic [Q_W-1:0] q;
        logic [Q_W-1:0] dvd;
        logic [31:0]    r24;
        t_side          side;
    } t_dv;

endpackage

`default_nettype wire

[hdl/psfr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface psfr_in_if;
    import psfr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord a_x;
    t_coord a_y;
    t_coord a_z;
    t_coord b_x;
    t_coord b_y;
    t_coord b_z;
    logic   a_region;
    logic   b_region;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, a_region, b_region,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, a_region, b_region,
        output ready
    );
endinterface

`default_nettype wire

[hdl/psfr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface psfr_out_if;
    import psfr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord force_x;
    t_coord force_y;
    t_coord force_z;
    logic   within_cutoff;
    logic   saturated;

    modport source (
        output valid, force_x, force_y, force_z, within_cutoff, saturated,
        input  ready
    );

    modport sink (
        input  valid, force_x, force_y, force_z, within_cutoff, saturated,
        output ready
    );
endinterface

`default_nettype wire

[hdl/pairwise_spring_force_regional_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Harmonic spring force between two nodes with a distance cutoff. Each beat on
// i_pair carries two Q16.16 positions and their region numbers; the matching
// beat on o_force carries k*(1 - L/r)*(B - A) in Q16.16, where k and L are the
// averages of the two regions' table entries, saturated per component. Pairs at
// or beyond the cutoff, or coincident, give zero force. The block takes one beat
// per clock unless every stage is full and o_force stalls. The pipe holds an
// 8-stage square root and a 14-stage divider, each doing four digit steps per
// stage. Results leave in order, and a stall on o_force holds the pipe without
// loss while empty stages keep taking new beats. Configuration must be written on
// the plain write port only while no beats are in flight; the block does not check.
module pairwise_spring_force_regional_top #(
    parameter int DIMS = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    psfr_in_if.sink                              i_pair,
    psfr_out_if.source                           o_force,
    input  logic                                 i_cfg_we,
    input  logic [psfr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  psfr_pkg::t_cfg                       i_cfg_wdata
);
    import psfr_pkg::*;

    // Configuration registers.
    t_cfg r_k0, r_k1, r_l0, r_l1, r_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0  <= RST_K0;
            r_k1  <= RST_K1;
            r_l0  <= RST_L0;
            r_l1  <= RST_L1;
            r_cut <= RST_CUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_K0:  r_k0  <= i_cfg_wdata;
                CFG_K1:  r_k1  <= i_cfg_wdata;
                CFG_L0:  r_l0  <= i_cfg_wdata;
                CFG_L1:  r_l1  <= i_cfg_wdata;
                CFG_CUT: r_cut <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Valid bits and per-stage advance; a stage moves when it is empty or the
    // stage after it moves.
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] en;
    logic [N_STG-1:0] vin;

    always_comb begin
        en[N_STG-1] = !r_vld[N_STG-1] || o_force.ready;
        for (int s = N_STG - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
        vin = {r_vld[N_STG-2:0], i_pair.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N_STG; s++) begin
                if (en[s]) begin
                    r_vld[s] <= vin[s];
                end
            end
        end
    end

    assign i_pair.ready = en[0];

    // Stage 0: differences, clamp detection and region table lookup.
    t_side r_s0_side, n_s0_side;
    logic  r_s0_big, n_s0_big;

    always_comb begin
        logic signed [32:0] dd [3];
        logic [32:0]        dmag;
        logic [24:0]        rsum;
        t_cfg               ka, kb, la, lb;
        dd[0] = {i_pair.b_x[31], i_pair.b_x} - {i_pair.a_x[31], i_pair.a_x};
        dd[1] = {i_pair.b_y[31], i_pair.b_y} - {i_pair.a_y[31], i_pair.a_y};
        dd[2] = {i_pair.b_z[31], i_pair.b_z} - {i_pair.a_z[31], i_pair.a_z};
        n_s0_side = '0;
        n_s0_big  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (i >= DIMS) begin
                dd[i] = '0;
            end
            dmag = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
            n_s0_side.sat_d   = n_s0_side.sat_d | (dd[i][32] ^ dd[i][31]);
            n_s0_big          = n_s0_big | (|dmag[32:24]);
            n_s0_side.dm[i]   = dmag[23:0];
            n_s0_side.dneg[i] = dd[i][32];
        end
        ka = i_pair.a_region ? r_k1 : r_k0;
        kb = i_pair.b_region ? r_k1 : r_k0;
        la = i_pair.a_region ? r_l1 : r_l0;
        lb = i_pair.b_region ? r_l1 : r_l0;
        n_s0_side.ksum   = {1'b0, ka} + {1'b0, kb};
        rsum             = {1'b0, la} + {1'b0, lb};
        n_s0_side.rest24 = {rsum, 7'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_DIFF]) begin
            r_s0_side <= n_s0_side;
            r_s0_big  <= n_s0_big;
        end
    end

    // Stage 1: squares of the differences and of the cutoff.
    t_side       r_s1_side;
    logic        r_s1_big;
    logic [47:0] r_s1_sq [3];
    logic [47:0] r_s1_cut2;

    always_ff @(posedge i_clk) begin
        if (en[ST_SQR]) begin
            r_s1_side <= r_s0_side;
            r_s1_big  <= r_s0_big;
            for (int i = 0; i < 3; i++) begin
                r_s1_sq[i] <= {24'b0, r_s0_side.dm[i]} * {24'b0, r_s0_side.dm[i]};
            end
            r_s1_cut2 <= {24'b0, r_cut} * {24'b0, r_cut};
        end
    end

    // Stage 2: squared length and the cutoff test.
    t_side       r_s2_side, n_s2_side;
    logic [63:0] r_s2_x;
    logic [49:0] dsq;

    always_comb begin
        dsq = {2'b0, r_s1_sq[0]} + {2'b0, r_s1_sq[1]} + {2'b0, r_s1_sq[2]};
        n_s2_side        = r_s1_side;
        n_s2_side.in_cut = !r_s1_big && (dsq != '0) && (dsq < {2'b0, r_s1_cut2});
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r_s2_side <= n_s2_side;
            r_s2_x    <= {dsq[47:0], 16'b0};
        end
    end

    // Square root, two input bits per step.
    t_sq r_sq [SQ_STG];

    for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
        t_sq cur, nxt;

        if (g == 0) begin : g_first
            assign cur = '{rem: '0, root: '0, x: r_s2_x, side: r_s2_side};
        end else begin : g_next
            assign cur = r_sq[g-1];
        end

        always_comb begin
            logic [35:0] t;
            logic [35:0] trial;
            nxt = cur;
            for (int k = 0; k < SQ_STEP; k++) begin
                t     = {nxt.rem, nxt.x[63:62]};
                trial = {2'b0, nxt.root, 2'b01};
                if (t >= trial) begin
                    t        = t - trial;
                    nxt.root = {nxt.root[30:0], 1'b1};
                end else begin
                    nxt.root = {nxt.root[30:0], 1'b0};
                end
                nxt.rem = t[33:0];
                nxt.x   = {nxt.x[61:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[ST_RT0+g]) begin
                r_sq[g] <= nxt;
            end
        end
    end

    // Distance minus rest length, as magnitude and sign.
    t_side       r_dev_side, n_dev_side;
    logic [31:0] r_dev_r24;
    logic [31:0] r_dev_adiff;
    t_sq         sq_last;

    assign sq_last = r_sq[SQ_STG-1];

    always_comb begin
        n_dev_side      = sq_last.side;
        n_dev_side.cneg = sq_last.root < sq_last.side.rest24;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_DEV]) begin
            r_dev_side  <= n_dev_side;
            r_dev_r24   <= sq_last.root;
            r_dev_adiff <= n_dev_side.cneg ?
                           sq_last.side.rest24 - sq_last.root :
                           sq_last.root - sq_last.side.rest24;
        end
    end

    // Spring constant times the deviation.
    t_side       r_kpr_side;
    logic [31:0] r_kpr_r24;
    logic [56:0] r_kpr_prod;

    always_ff @(posedge i_clk) begin
        if (en[ST_KPR]) begin
            r_kpr_side <= r_dev_side;
            r_kpr_r24  <= r_dev_r24;
            r_kpr_prod <= {32'b0, r_dev_side.ksum} * {25'b0, r_dev_adiff};
        end
    end

    // Divider by the distance, one quotient bit per step. The top seven
    // dividend bits start as the remainder since the quotient fits Q_W bits.
    t_dv r_dv [DV_STG];

    for (genvar g = 0; g < DV_STG; g++) begin : g_div
        t_dv cur, nxt;

        if (g == 0) begin : g_first
            assign cur = '{rem: {25'b0, r_kpr_prod[56:50]}, q: '0,
                           dvd: {r_kpr_prod[49:0], 6'b0},
                           r24: r_kpr_r24, side: r_kpr_side};
        end else begin : g_next
            assign cur = r_dv[g-1];
        end

        always_comb begin
            logic [32:0] t;
            nxt = cur;
            for (int k = 0; k < DV_STEP; k++) begin
                t = {nxt.rem, nxt.dvd[Q_W-1]};
                if (t >= {1'b0, nxt.r24}) begin
                    t     = t - {1'b0, nxt.r24};
                    nxt.q = {nxt.q[Q_W-2:0], 1'b1};
                end else begin
                    nxt.q = {nxt.q[Q_W-2:0], 1'b0};
                end
                nxt.rem = t[31:0];
                nxt.dvd = {nxt.dvd[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[ST_DV0+g]) begin
                r_dv[g] <= nxt;
            end
        end
    end

    // Coefficient times each difference, as two partial products.
    t_side       r_pp_side;
    logic [55:0] r_pp_lo [3];
    logic [47:0] r_pp_hi [3];
    t_dv         dv_last;

    assign dv_last = r_dv[DV_STG-1];

    always_ff @(posedge i_clk) begin
        if (en[ST_PP]) begin
            r_pp_side <= dv_last.side;
            for (int i = 0; i < 3; i++) begin
                r_pp_lo[i] <= {24'b0, dv_last.q[31:0]} * {32'b0, dv_last.side.dm[i]};
                r_pp_hi[i] <= {24'b0, dv_last.q[Q_W-1:32]} * {24'b0, dv_last.side.dm[i]};
            end
        end
    end

    // Sum the partial products, detect overflow and round to Q16.16.
    t_side       r_mag_side;
    logic [2:0]  r_mag_big, n_mag_big;
    logic [32:0] r_mag [3];
    logic [32:0] n_mag [3];

    always_comb begin
        logic [79:0] full;
        logic [55:0] rnd;
        for (int i = 0; i < 3; i++) begin
            full         = {24'b0, r_pp_lo[i]} + {r_pp_hi[i], 32'b0};
            n_mag_big[i] = |full[79:55];
            rnd          = {1'b0, full[54:0]} + 56'd4194304;
            n_mag[i]     = rnd[55:23];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_MAG]) begin
            r_mag_side <= r_pp_side;
            r_mag_big  <= n_mag_big;
            r_mag      <= n_mag;
        end
    end

    // Output register: sign, saturation and the cutoff mask.
    t_coord r_out_f [3];
    t_coord n_out_f [3];
    logic   r_out_in, r_out_sat, n_out_sat;

    always_comb begin
        logic neg;
        n_out_sat = r_mag_side.sat_d;
        for (int i = 0; i < 3; i++) begin
            neg        = r_mag_side.cneg ^ r_mag_side.dneg[i];
            n_out_f[i] = '0;
            if (r_mag_side.in_cut && (i < DIMS)) begin
                if (neg) begin
                    if (r_mag_big[i] || (r_mag[i] > 33'h080000000)) begin
                        n_out_f[i] = 32'sh80000000;
                        n_out_sat  = 1'b1;
                    end else begin
                        n_out_f[i] = t_coord'(~r_mag[i][31:0] + 32'd1);
                    end
                end else begin
                    if (r_mag_big[i] || (r_mag[i] > 33'h07FFFFFFF)) begin
                        n_out_f[i] = 32'sh7FFFFFFF;
                        n_out_sat  = 1'b1;
                    end else begin
                        n_out_f[i] = t_coord'(r_mag[i][31:0]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out_f   <= n_out_f;
            r_out_in  <= r_mag_side.in_cut;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_force.valid         = r_vld[N_STG-1];
    assign o_force.force_x       = r_out_f[0];
    assign o_force.force_y       = r_out_f[1];
    assign o_force.force_z       = r_out_f[2];
    assign o_force.within_cutoff = r_out_in;
    assign o_force.saturated     = r_out_sat;

    // A pair outside the cutoff carries no force.
    a_zero_outside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_force.valid && !o_force.within_cutoff |->
            o_force.force_x == 0 && o_force.force_y == 0 && o_force.force_z == 0)
        else $error("nonzero force outside cutoff");

    // Input back-pressure only arises when every stage is full and the output stalls.
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pair.ready |-> (&r_vld) && !o_force.ready)
        else $error("input stalled with a free stage");

    // A beat that leaves the last stage is replaced by what the stage before held.
    a_shift : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_force.valid && o_force.ready |=> r_vld[N_STG-1] == $past(r_vld[N_STG-2]))
        else $error("pipeline lost or duplicated a beat");

endmodule

`default_nettype wire

[bench/pairwise_spring_force_regional_top_tb.sv]
`timescale 1ns / 1ps

module pairwise_spring_force_regional_top_tb;
    import psfr_pkg::*;

    localparam int NUM_AXES    = 3;
    localparam int LATENCY     = 30;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 260;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam logic [63:0] PROD_LIMIT = 64'd1 << 55;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        t_coord a [3];
        t_coord b [3];
        logic   a_region;
        logic   b_region;
    } t_pair;

    typedef struct {
        t_coord f [3];
        logic   within_cutoff;
        logic   saturated;
    } t_force;

    // Scoreboard: holds the spring tables and the forces still to come.
    class force_scoreboard;
        logic [63:0] k_tab [2];
        logic [63:0] rest_tab [2];
        logic [63:0] cutoff;
        t_force      pending [$];
        int          errors;

        function new();
            k_tab[0]    = 64'(RST_K0);
            k_tab[1]    = 64'(RST_K1);
            rest_tab[0] = 64'(RST_L0);
            rest_tab[1] = 64'(RST_L1);
            cutoff      = 64'(RST_CUT);
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_cfg value);
            case (idx)
                CFG_K0:  k_tab[0] = 64'(value);
                CFG_K1:  k_tab[1] = 64'(value);
                CFG_L0:  rest_tab[0] = 64'(value);
                CFG_L1:  rest_tab[1] = 64'(value);
                CFG_CUT: cutoff = 64'(value);
                default: ;
            endcase
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function t_force spring_force(t_pair p);
            t_force      r;
            longint      d [3];
            longint      t;
            logic [63:0] m, dsq, ksum, rest24, r24, adiff, coef, dm, mag;
            logic        cneg, neg, big;
            r.saturated     = 0;
            r.within_cutoff = 0;
            dsq = 0;
            for (int i = 0; i < 3; i++) begin
                r.f[i] = 0;
                d[i]   = 0;
                if (i < NUM_AXES) begin
                    t = longint'(p.b[i]) - longint'(p.a[i]);
                    if (t > S32_MAX) begin t = S32_MAX; r.saturated = 1; end
                    if (t < S32_MIN) begin t = S32_MIN; r.saturated = 1; end
                    d[i] = t;
                    m    = (t < 0) ? -t : t;
                    dsq  = dsq + m * m;
                end
            end
            if (dsq != 0 && dsq < cutoff * cutoff) begin
                ksum   = k_tab[p.a_region] + k_tab[p.b_region];
                rest24 = (rest_tab[p.a_region] + rest_tab[p.b_region]) << 7;
                r24    = int_sqrt(dsq << 16);
                cneg   = r24 < rest24;
                adiff  = cneg ? rest24 - r24 : r24 - rest24;
                coef   = ((ksum * adiff) << 6) / r24;
                r.within_cutoff = 1;
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (d[i] != 0 && coef != 0) begin
                        dm  = (d[i] < 0) ? -d[i] : d[i];
                        neg = cneg != (d[i] < 0);
                        big = coef > (PROD_LIMIT - 1) / dm;
                        mag = big ? 64'd0 : (coef * dm + (64'd1 << 22)) >> 23;
                        if (neg) begin
                            if (big || mag > 64'h8000_0000) begin
                                r.f[i] = 32'h8000_0000;
                                r.saturated = 1;
                            end else begin
                                r.f[i] = -mag[31:0];
                            end
                        end else begin
                            if (big || mag > 64'h7FFF_FFFF) begin
                                r.f[i] = 32'h7FFF_FFFF;
                                r.saturated = 1;
                            end else begin
                                r.f[i] = mag[31:0];
                            end
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_pair(t_pair p);
            pending.push_back(spring_force(p));
        endfunction

        function void check_force(t_force got);
            t_force want;
            if (pending.size() == 0) begin
                $error("force beat arrived with no pair outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.f[i] !== want.f[i]) begin
                    $error("force_%s expected %0d got %0d", (i == 0) ? "x" :
                           (i == 1) ? "y" : "z", want.f[i], got.f[i]);
                    errors++;
                end
            end
            if (got.within_cutoff !== want.within_cutoff) begin
                $error("within_cutoff expected %0d got %0d",
                       want.within_cutoff, got.within_cutoff);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated expected %0d got %0d", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_cfg i_cfg_wdata;

    psfr_in_if  pair_if ();
    psfr_out_if force_if ();

    force_scoreboard sb = new();

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  n_in_beats;
    int  n_out_beats;

    pairwise_spring_force_regional_top #(.DIMS(NUM_AXES)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (pair_if),
        .o_force     (force_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: sample at the falling edge, take the beat at the rising edge.
    initial begin
        t_force got;
        logic   v, r;
        int     hold_left;
        hold_left = 0;
        force_if.ready <= 0;
        forever begin
            @(negedge i_clk);
            v = force_if.valid;
            r = force_if.ready;
            got.f[0] = force_if.force_x;
            got.f[1] = force_if.force_y;
            got.f[2] = force_if.force_z;
            got.within_cutoff = force_if.within_cutoff;
            got.saturated = force_if.saturated;
            @(posedge i_clk);
            if (v && r && i_rst_n) begin
                sb.check_force(got);
                n_out_beats++;
            end
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                force_if.ready <= 0;
            end else begin
                force_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    initial begin
        int quiet, last_in, last_out;
        quiet = 0;
        last_in = 0;
        last_out = 0;
        forever begin
            @(posedge i_clk);
            if (n_in_beats != last_in || n_out_beats != last_out) quiet = 0;
            else quiet++;
            last_in  = n_in_beats;
            last_out = n_out_beats;
            if (quiet >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one pair, with a random idle gap first, and wait for its acceptance.
    task automatic send_pair(t_pair p);
        logic r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pair_if.valid <= 0;
            @(posedge i_clk);
        end
        pair_if.valid    <= 1;
        pair_if.a_x      <= p.a[0];
        pair_if.a_y      <= p.a[1];
        pair_if.a_z      <= p.a[2];
        pair_if.b_x      <= p.b[0];
        pair_if.b_y      <= p.b[1];
        pair_if.b_z      <= p.b[2];
        pair_if.a_region <= p.a_region;
        pair_if.b_region <= p.b_region;
        do begin
            @(negedge i_clk);
            r = pair_if.ready;
            @(posedge i_clk);
        end while (!r);
        sb.note_pair(p);
        n_in_beats++;
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, t_cfg value);
        i_cfg_we    <= 1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    function automatic t_pair pair_of(longint dx, longint dy, longint dz,
                                      logic ra, logic rb);
        t_pair  p;
        longint dv [3];
        dv[0] = dx;
        dv[1] = dy;
        dv[2] = dz;
        for (int i = 0; i < 3; i++) begin
            p.a[i] = $urandom;
            // Keep B inside the 32-bit range by stepping the other way if needed.
            if (longint'(p.a[i]) + dv[i] > S32_MAX || longint'(p.a[i]) + dv[i] < S32_MIN)
                p.b[i] = p.a[i] - dv[i][31:0];
            else
                p.b[i] = p.a[i] + dv[i][31:0];
        end
        p.a_region = ra;
        p.b_region = rb;
        return p;
    endfunction

    // Mostly pairs near or inside the cutoff, the rest unrestricted noise.
    function automatic t_pair random_pair();
        t_pair  p;
        longint dv [3];
        longint amp;
        if ($urandom_range(0, 9) < 8) begin
            amp = longint'(sb.cutoff) >> $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) amp = 64'd256;
            for (int i = 0; i < 3; i++) begin
                dv[i] = ($urandom_range(0, 4) == 0) ? 0 : longint'($urandom_range(0, amp));
                if ($urandom_range(0, 1)) dv[i] = -dv[i];
            end
            p = pair_of(dv[0], dv[1], dv[2], 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        end else begin
            for (int i = 0; i < 3; i++) begin
                p.a[i] = $urandom;
                p.b[i] = $urandom;
            end
            p.a_region = 1'($urandom_range(0, 1));
            p.b_region = 1'($urandom_range(0, 1));
        end
        return p;
    endfunction

    function automatic t_cfg rand_cfg();
        case ($urandom_range(0, 3))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom_range(0, 24'hFF_FFFF));
            default: return 24'($urandom_range(0, 24'h04_0000));
        endcase
    endfunction

    // Main sequence: reset, directed pairs, then phases of random pairs.
    initial begin
        t_pair p;
        longint c;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        n_in_beats     = 0;
        n_out_beats    = 0;
        i_rst_n        <= 0;
        i_cfg_we       <= 0;
        i_cfg_idx      <= CFG_K0;
        i_cfg_wdata    <= 0;
        pair_if.valid  <= 0;
        pair_if.a_x    <= 0;
        pair_if.a_y    <= 0;
        pair_if.a_z    <= 0;
        pair_if.b_x    <= 0;
        pair_if.b_y    <= 0;
        pair_if.b_z    <= 0;
        pair_if.a_region <= 0;
        pair_if.b_region <= 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed pairs under the reset tables.
        c = longint'(sb.cutoff);
        p = pair_of(0, 0, 0, 0, 0);
        send_pair(p);
        p.a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        p.b = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pair(p);
        p.a = '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000};
        p.b = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF};
        send_pair(p);
        send_pair(pair_of(c, 0, 0, 0, 1));
        send_pair(pair_of(c - 1, 0, 0, 1, 0));
        send_pair(pair_of(0, -(c - 1), 0, 1, 1));
        send_pair(pair_of(0, 0, c / 2, 0, 0));
        send_pair(pair_of(1, 0, 0, 0, 0));
        send_pair(pair_of(-1, -1, -1, 1, 1));
        send_pair(pair_of(c / 4, -(c / 4), c / 4, 0, 1));
        // Distance equal to the mean rest length: zero force but inside.
        send_pair(pair_of(longint'(RST_L0), 0, 0, 0, 0));
        send_pair(pair_of(longint'(RST_L1), 0, 0, 1, 1));
        send_pair(pair_of(-(c / 3), c / 5, 0, 1, 0));
        for (int i = 0; i < 5; i++) send_pair(random_pair());

        for (int ph = 0; ph < N_PHASES; ph++) begin
            pair_if.valid <= 0;
            while (sb.pending.size() != 0) @(posedge i_clk);
            repeat (LATENCY + 10) @(posedge i_clk);
            case (ph)
                0: ;
                1: begin
                    write_cfg(CFG_K0, 24'hFF_FFFF);
                    write_cfg(CFG_K1, 24'hFF_FFFF);
                    write_cfg(CFG_L0, 24'd0);
                    write_cfg(CFG_L1, 24'd0);
                    write_cfg(CFG_CUT, 24'hFF_FFFF);
                end
                2: begin
                    write_cfg(CFG_K0, 24'd0);
                    write_cfg(CFG_K1, 24'd0);
                    write_cfg(CFG_CUT, 24'd0);
                    write_cfg(CFG_IDX_UNUSED, 24'hFF_FFFF);
                end
                3: begin
                    write_cfg(CFG_K0, 24'h01_0000);
                    write_cfg(CFG_K1, 24'h00_8000);
                    write_cfg(CFG_L0, 24'hFF_FFFF);
                    write_cfg(CFG_L1, 24'hFF_FFFF);
                    write_cfg(CFG_CUT, 24'hFF_FFFF);
                end
                default: begin
                    write_cfg(CFG_K0, rand_cfg());
                    write_cfg(CFG_K1, rand_cfg());
                    write_cfg(CFG_L0, rand_cfg());
                    write_cfg(CFG_L1, rand_cfg());
                    write_cfg(CFG_CUT, 24'($urandom_range(1, 24'hFF_FFFF)));
                end
            endcase
            i_cfg_we <= 0;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // Long receiver hold-off so the pipe fills and back-pressures.
            if (ph == 4) hold_req = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_pair(random_pair());
        end

        pair_if.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
